@@ rtl/mrfm_pkg.sv @@
// ----------------------------------------------------------------------------
// mrfm_pkg
// Shared constants, types and the CRC-16/Modbus byte step for the response
// frame matcher.
// ----------------------------------------------------------------------------
package mrfm_pkg;

    // Window depth default and frame geometry.
    localparam int MAX_FRAME_BYTES_DEF = 17;
    localparam int IDX_W               = 5;

    localparam logic [IDX_W-1:0] POS_FRAME_LEN  = 5'd9;
    localparam logic [IDX_W-1:0] FULL_FRAME_LEN = 5'd17;
    localparam logic [7:0]       POS_COUNT      = 8'h04;
    localparam logic [7:0]       FULL_COUNT     = 8'h0C;

    // CRC-16/Modbus constants.
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Configuration register indexes.
    localparam logic [1:0] REG_RESPONSE_MODE  = 2'd0;
    localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd1;
    localparam logic [1:0] REG_FUNCTION_CODE  = 2'd2;

    // Configuration reset values.
    localparam logic       RESET_MODE     = 1'b1;
    localparam logic [7:0] RESET_ADDRESS  = 8'h01;
    localparam logic [7:0] RESET_FUNCTION = 8'h04;

    // One byte read back from the window during a frame scan.
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } beat_t;

    // Fold one byte into the reflected CRC, one bit per step.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] acc;
        acc = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (acc[0]) begin
                acc = (acc >> 1) ^ CRC_POLY;
            end else begin
                acc = acc >> 1;
            end
        end
        return acc;
    endfunction

endpackage

@@ rtl/mrfm_window_ram.sv @@
// ----------------------------------------------------------------------------
// mrfm_window_ram
// Circular byte store for the receive window, one write port and one read
// port with registered read data.
// ----------------------------------------------------------------------------
module mrfm_window_ram #(
    parameter int DEPTH  = mrfm_pkg::MAX_FRAME_BYTES_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered read data.
    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/mrfm_frame_check.sv @@
// ----------------------------------------------------------------------------
// mrfm_frame_check
// Walks the frame bytes as they come out of the window store: header
// compares, running CRC, data byte collection and the final CRC compare.
// ----------------------------------------------------------------------------
module mrfm_frame_check (
    input  logic                           clk,
    input  mrfm_pkg::beat_t                beat,
    input  logic [7:0]                     data_byte,
    input  logic                           mode,
    input  logic [mrfm_pkg::IDX_W-1:0]     frame_len,
    input  logic [7:0]                     device_address,
    input  logic [7:0]                     function_code,
    output logic                           match,
    output logic signed [31:0]             position,
    output logic signed [31:0]             velocity,
    output logic signed [31:0]             drive_current
);

    logic [15:0] crc_reg, crc_next;
    logic        ok_reg, ok_next;
    logic [95:0] data_reg, data_next;

    logic [mrfm_pkg::IDX_W-1:0] crc_lo_idx;
    logic [mrfm_pkg::IDX_W-1:0] crc_hi_idx;
    logic [7:0]                 count_exp;

    assign crc_lo_idx = frame_len - mrfm_pkg::IDX_W'(2);
    assign crc_hi_idx = frame_len - mrfm_pkg::IDX_W'(1);
    assign count_exp  = mode ? mrfm_pkg::FULL_COUNT : mrfm_pkg::POS_COUNT;

    // Per-byte update of CRC, verdict and data shift register.
    always_comb begin
        crc_next  = crc_reg;
        ok_next   = ok_reg;
        data_next = data_reg;
        if (beat.valid) begin
            if (beat.idx == '0) begin
                crc_next = mrfm_pkg::crc_byte(mrfm_pkg::CRC_INIT, data_byte);
                ok_next  = (data_byte == device_address);
            end else if (beat.idx == crc_lo_idx) begin
                ok_next = ok_reg && (data_byte == crc_reg[7:0]);
            end else if (beat.idx == crc_hi_idx) begin
                ok_next = ok_reg && (data_byte == crc_reg[15:8]);
            end else begin
                crc_next = mrfm_pkg::crc_byte(crc_reg, data_byte);
                if (beat.idx == mrfm_pkg::IDX_W'(1)) begin
                    ok_next = ok_reg && (data_byte == function_code);
                end else if (beat.idx == mrfm_pkg::IDX_W'(2)) begin
                    ok_next = ok_reg && (data_byte == count_exp);
                end else begin
                    data_next = {data_reg[87:0], data_byte};
                end
            end
        end
    end

    // Working registers for CRC, verdict and data; the first byte restarts CRC and verdict.
    always_ff @(posedge clk) begin
        crc_reg  <= crc_next;
        ok_reg   <= ok_next;
        data_reg <= data_next;
    end

    // Result fields; position mode collects only four data bytes.
    assign match         = ok_reg;
    assign position      = mode ? data_reg[95:64] : data_reg[31:0];
    assign velocity      = mode ? data_reg[63:32] : 32'sd0;
    assign drive_current = mode ? data_reg[31:0]  : 32'sd0;

endmodule

@@ rtl/modbus_response_frame_matcher.sv @@
// ----------------------------------------------------------------------------
// modbus_response_frame_matcher
// Sliding receive window with Modbus RTU read-input-registers response
// matching: header checks, CRC-16/Modbus and big-endian value extraction.
// ----------------------------------------------------------------------------
//  Channel   Signals                                   Direction
//  in        in_valid, in_ready, rx_byte               byte transactions in
//  out       out_valid, out_ready, position, velocity,  result transactions out
//            drive_current
//  cfg       cfg_valid, cfg_ready, cfg_index, cfg_data  register writes in
//
//  A byte that cannot complete a frame is only written to the window. A
//  byte that can complete one starts a scan (L = 9 in position mode, 17
//  in full mode): the scan reads the L frame bytes from the window store
//  one per cycle through its single read port and folds each into the CRC.
//  The result sits in an output register, so a new byte is taken while it
//  waits; a new match stalls in its final cycle until that register frees.
//  Reset empties the window (fill count zero); no clearing pass is needed.
// ----------------------------------------------------------------------------
module modbus_response_frame_matcher #(
    parameter int MAX_FRAME_BYTES = mrfm_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] position,
    output logic signed [31:0] velocity,
    output logic signed [31:0] drive_current,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data
);

    localparam int ADDR_W  = $clog2(MAX_FRAME_BYTES);
    localparam int PTR_W   = ADDR_W + 1;
    localparam int FILL_W  = $clog2(MAX_FRAME_BYTES + 1);
    localparam bit FULL_OK = (MAX_FRAME_BYTES >= 17);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_FRAME_BYTES - 1);
    localparam logic [FILL_W-1:0] FILL_MAX  = FILL_W'(MAX_FRAME_BYTES);
    localparam logic [PTR_W-1:0]  DEPTH_P   = PTR_W'(MAX_FRAME_BYTES);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_FLUSH = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]          fill_reg, fill_next;
    logic [mrfm_pkg::IDX_W-1:0] iss_reg, iss_next;
    mrfm_pkg::beat_t            beat_reg, beat_next;

    logic       mode_reg;
    logic [7:0] dev_addr_reg;
    logic [7:0] func_code_reg;

    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] position_reg, velocity_reg, current_reg;
    logic               load_out;

    logic                       in_fire;
    logic [mrfm_pkg::IDX_W-1:0] frame_len;
    logic [FILL_W-1:0]          fill_inc;
    logic                       len_fits;
    logic                       frame_ready;
    logic [PTR_W-1:0]           start_sum;
    logic [PTR_W-1:0]           start_wrap;
    logic                       rd_en;

    logic [7:0]         rd_data;
    logic               chk_match;
    logic signed [31:0] chk_position, chk_velocity, chk_current;

    assign in_fire   = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign frame_len = mode_reg ? mrfm_pkg::FULL_FRAME_LEN : mrfm_pkg::POS_FRAME_LEN;
    assign len_fits  = !mode_reg || FULL_OK;

    // Fill count after the incoming byte, saturating at the window depth.
    assign fill_inc    = (fill_reg == FILL_MAX) ? fill_reg : fill_reg + FILL_W'(1);
    assign frame_ready = len_fits && (6'(fill_inc) >= 6'(frame_len));

    // Oldest frame byte sits L-1 slots behind the byte being written.
    assign start_sum  = PTR_W'(wr_ptr_reg) + DEPTH_P
                      - PTR_W'(frame_len - mrfm_pkg::IDX_W'(1));
    assign start_wrap = (start_sum >= DEPTH_P) ? start_sum - DEPTH_P : start_sum;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg      <= mrfm_pkg::RESET_MODE;
            dev_addr_reg  <= mrfm_pkg::RESET_ADDRESS;
            func_code_reg <= mrfm_pkg::RESET_FUNCTION;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                mrfm_pkg::REG_RESPONSE_MODE:  mode_reg      <= cfg_data[0];
                mrfm_pkg::REG_DEVICE_ADDRESS: dev_addr_reg  <= cfg_data;
                mrfm_pkg::REG_FUNCTION_CODE:  func_code_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer: write the byte, then scan the frame out of the store.
    // Writes happen only in idle and reads only while scanning, so the two
    // ports never touch the same slot in one cycle.
    always_comb begin
        state_next  = state_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        iss_next    = iss_reg;
        rd_en       = 1'b0;
        load_out    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    wr_ptr_next = (wr_ptr_reg == LAST_ADDR) ? '0
                                                            : wr_ptr_reg + ADDR_W'(1);
                    fill_next   = fill_inc;
                    if (frame_ready) begin
                        rd_ptr_next = start_wrap[ADDR_W-1:0];
                        iss_next    = '0;
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                rd_en       = 1'b1;
                rd_ptr_next = (rd_ptr_reg == LAST_ADDR) ? '0 : rd_ptr_reg + ADDR_W'(1);
                iss_next    = iss_reg + mrfm_pkg::IDX_W'(1);
                if (iss_reg == frame_len - mrfm_pkg::IDX_W'(1)) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!chk_match) begin
                    state_next = ST_IDLE;
                end else if (!out_valid_reg || out_ready) begin
                    load_out   = 1'b1;
                    fill_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Read beat travels alongside the store's read latency.
    assign beat_next.valid = rd_en;
    assign beat_next.idx   = iss_reg;

    // Output hold: valid drops on a taken transaction, rises on a load.
    assign out_valid_next = (out_valid_reg && !out_ready) || load_out;

    // Control state.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            fill_reg      <= '0;
            iss_reg       <= '0;
            beat_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            fill_reg      <= fill_next;
            iss_reg       <= iss_next;
            beat_reg      <= beat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk) begin
        if (load_out) begin
            position_reg <= chk_position;
            velocity_reg <= chk_velocity;
            current_reg  <= chk_current;
        end
    end

    assign out_valid     = out_valid_reg;
    assign position      = position_reg;
    assign velocity      = velocity_reg;
    assign drive_current = current_reg;

    mrfm_window_ram #(
        .DEPTH  (MAX_FRAME_BYTES),
        .ADDR_W (ADDR_W)
    ) u_window_ram (
        .clk     (clk),
        .wr_en   (in_fire),
        .wr_addr (wr_ptr_reg),
        .wr_data (rx_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_data)
    );

    mrfm_frame_check u_frame_check (
        .clk            (clk),
        .beat           (beat_reg),
        .data_byte      (rd_data),
        .mode           (mode_reg),
        .frame_len      (frame_len),
        .device_address (dev_addr_reg),
        .function_code  (func_code_reg),
        .match          (chk_match),
        .position       (chk_position),
        .velocity       (chk_velocity),
        .drive_current  (chk_current)
    );

endmodule

@@ tb/tb_modbus_response_frame_matcher.sv @@
// ----------------------------------------------------------------------------
// tb_modbus_response_frame_matcher
// Drives received bytes into the Modbus response frame matcher and checks
// every decoded reading against a bit-accurate predictor of the sliding
// window, header checks and CRC-16/Modbus. Stimulus is mostly well-formed
// response frames with random content, mixed with broken frames and noise,
// across several register settings and with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_modbus_response_frame_matcher;

    // Frame geometry and CRC constants as the protocol defines them.
    localparam int          WINDOW_DEPTH    = 17;
    localparam int          LEN_POSITION    = 9;
    localparam int          LEN_FULL        = 17;
    localparam logic [7:0]  BYTE_COUNT_POS  = 8'h04;
    localparam logic [7:0]  BYTE_COUNT_FULL = 8'h0C;
    localparam logic [15:0] CRC_SEED        = 16'hFFFF;
    localparam logic [15:0] CRC_REFLECTED   = 16'hA001;

    // An index with no register behind it; writes to it must be ignored.
    localparam logic [1:0]  REG_UNUSED      = 2'd3;

    localparam int SETTLE_CYCLES = 40;
    localparam int LIMIT_CYCLES  = 300000;

    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_ADDR,
        FRAME_BAD_FUNC,
        FRAME_BAD_COUNT,
        FRAME_BAD_CRC,
        FRAME_CUT_SHORT,
        FRAME_OTHER_MODE
    } frame_kind_t;

    // One decoded drive reading.
    typedef struct {
        logic [31:0] position;
        logic [31:0] velocity;
        logic [31:0] drive_current;
    } reading_t;

    // Tracks the receive window and register settings, predicts the readings
    // that each byte produces and checks the readings that come out.
    class modbus_frame_tracker;
        bit [7:0]    window_bytes[WINDOW_DEPTH];
        int unsigned fill_level         = 0;
        bit          response_mode      = 1'b1;
        bit [7:0]    device_address     = 8'h01;
        bit [7:0]    function_code      = 8'h04;
        reading_t    pending_readings[$];
        int          readings_predicted = 0;
        int          fail_count         = 0;

        static function bit [15:0] crc16(bit [7:0] data_q[$]);
            bit [15:0] acc;
            acc = CRC_SEED;
            foreach (data_q[k])
            begin
                acc ^= {8'h00, data_q[k]};
                for (int b = 0; b < 8; b++)
                begin
                    acc = acc[0] ? ((acc >> 1) ^ CRC_REFLECTED) : (acc >> 1);
                end
            end
            return acc;
        endfunction

        function void apply_register(bit [1:0] index, bit [7:0] value);
            case (index)
                mrfm_pkg::REG_RESPONSE_MODE:  response_mode  = value[0];
                mrfm_pkg::REG_DEVICE_ADDRESS: device_address = value;
                mrfm_pkg::REG_FUNCTION_CODE:  function_code  = value;
                default: ;
            endcase
        endfunction

        // Slide one byte into the window and test the newest frame.
        function void take_byte(bit [7:0] value);
            int       frame_len;
            int       base;
            bit [7:0] count;
            bit [7:0] covered[$];
            bit [15:0] rx_crc;
            reading_t r;
            for (int i = 0; i < WINDOW_DEPTH - 1; i++)
            begin
                window_bytes[i] = window_bytes[i + 1];
            end
            window_bytes[WINDOW_DEPTH - 1] = value;
            if (fill_level < WINDOW_DEPTH)
            begin
                fill_level++;
            end

            frame_len = response_mode ? LEN_FULL : LEN_POSITION;
            count     = response_mode ? BYTE_COUNT_FULL : BYTE_COUNT_POS;
            if (frame_len > WINDOW_DEPTH || fill_level < frame_len)
            begin
                return;
            end
            base = WINDOW_DEPTH - frame_len;
            if (window_bytes[base] != device_address ||
                window_bytes[base + 1] != function_code ||
                window_bytes[base + 2] != count)
            begin
                return;
            end

            for (int i = 0; i < frame_len - 2; i++)
            begin
                covered.push_back(window_bytes[base + i]);
            end
            rx_crc = {window_bytes[base + frame_len - 1], window_bytes[base + frame_len - 2]};
            if (crc16(covered) != rx_crc)
            begin
                return;
            end

            r.position = {window_bytes[base + 3], window_bytes[base + 4],
                          window_bytes[base + 5], window_bytes[base + 6]};
            r.velocity      = 32'h0;
            r.drive_current = 32'h0;
            if (response_mode)
            begin
                r.velocity      = {window_bytes[base + 7], window_bytes[base + 8],
                                   window_bytes[base + 9], window_bytes[base + 10]};
                r.drive_current = {window_bytes[base + 11], window_bytes[base + 12],
                                   window_bytes[base + 13], window_bytes[base + 14]};
            end
            pending_readings.push_back(r);
            readings_predicted++;
            fill_level = 0;
        endfunction

        // Compare one delivered reading with the oldest prediction.
        function void check_reading(logic [31:0] pos, logic [31:0] vel, logic [31:0] cur);
            reading_t want;
            if (pending_readings.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display("Unexpected reading: position %h velocity %h current %h",
                             pos, vel, cur);
                end
                return;
            end
            want = pending_readings.pop_front();
            if (pos !== want.position || vel !== want.velocity ||
                cur !== want.drive_current)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display("Reading mismatch: expected position %h velocity %h current %h,",
                             want.position, want.velocity, want.drive_current);
                    $display("                  got      position %h velocity %h current %h",
                             pos, vel, cur);
                end
            end
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic [7:0]         rx_byte   = 8'h00;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] drive_current;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = 2'd0;
    logic [7:0]         cfg_data  = 8'h00;

    modbus_frame_tracker sb = new;
    bit                  quiet       = 1'b0;
    int                  byte_count  = 0;
    int                  cycle_count = 0;
    int                  stall_left  = 0;

    modbus_response_frame_matcher i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .position      (position),
        .velocity      (velocity),
        .drive_current (drive_current),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock with a period of 4 time units.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: random stall bursts, none in the quiet part.
    always @(negedge clk)
    begin
        if (!rst_n || quiet)
        begin
            out_ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Every reading transaction is checked at the edge that accepts it.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_reading(position, velocity, drive_current);
        end
    end

    // Mostly random bytes, with a bias toward the extreme values.
    function automatic bit [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One byte transaction, optionally preceded by an idle burst.
    task automatic send_byte(bit [7:0] value);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 3))
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_valid <= 1'b1;
        rx_byte  <= value;
        do @(posedge clk); while (!in_ready);
        sb.take_byte(value);
        byte_count++;
    endtask

    // One register write transaction.
    task automatic cfg_write(logic [1:0] index, logic [7:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        sb.apply_register(index, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stop sending and let every predicted reading and any scan in flight finish.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending_readings.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Build a response frame for the current settings, then damage it as asked.
    task automatic emit_frame(frame_kind_t kind, bit [7:0] payload[$]);
        bit [7:0]  frame_q[$];
        bit [15:0] crc;
        bit        full;
        int        n_data;
        int        pos;
        full   = sb.response_mode ^ (kind == FRAME_OTHER_MODE);
        n_data = full ? 12 : 4;
        frame_q.push_back(sb.device_address);
        frame_q.push_back(sb.function_code);
        frame_q.push_back(full ? BYTE_COUNT_FULL : BYTE_COUNT_POS);
        for (int i = 0; i < n_data; i++)
        begin
            frame_q.push_back(payload[i]);
        end
        crc = modbus_frame_tracker::crc16(frame_q);
        frame_q.push_back(crc[7:0]);
        frame_q.push_back(crc[15:8]);

        case (kind)
            FRAME_BAD_ADDR:  frame_q[0] ^= 8'($urandom_range(1, 255));
            FRAME_BAD_FUNC:  frame_q[1] ^= 8'($urandom_range(1, 255));
            FRAME_BAD_COUNT: frame_q[2] ^= 8'($urandom_range(1, 255));
            FRAME_BAD_CRC:
            begin
                pos = $urandom_range(3, frame_q.size() - 1);
                frame_q[pos] ^= 8'(1 << $urandom_range(0, 7));
            end
            FRAME_CUT_SHORT:
            begin
                repeat ($urandom_range(1, frame_q.size() - 1)) void'(frame_q.pop_back());
            end
            default: ;
        endcase

        foreach (frame_q[i])
        begin
            send_byte(frame_q[i]);
        end
    endtask

    // A stretch of random frames and noise of the given length in bytes.
    task automatic run_traffic(int n_bytes);
        int          stop_at;
        bit [7:0]    payload[$];
        frame_kind_t kind;
        stop_at = byte_count + n_bytes;
        while (byte_count < stop_at)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    send_byte($urandom_range(0, 3) == 0 ? sb.device_address : pick_byte());
                end
            end
            payload.delete();
            repeat (12) payload.push_back(pick_byte());
            if ($urandom_range(0, 99) < 65)
            begin
                kind = FRAME_GOOD;
            end
            else
            begin
                kind = frame_kind_t'($urandom_range(FRAME_BAD_ADDR, FRAME_OTHER_MODE));
            end
            emit_frame(kind, payload);
        end
    endtask

    // Register settings for one phase; early phases take the extremes.
    task automatic configure_phase(int phase);
        logic [7:0] mode_value;
        logic [7:0] addr_value;
        logic [7:0] func_value;
        mode_value = 8'($urandom_range(0, 255));
        addr_value = 8'($urandom_range(0, 255));
        func_value = 8'($urandom_range(0, 255));
        case (phase)
            0:
            begin
                mode_value = 8'h00;
                addr_value = 8'h00;
                func_value = 8'h00;
            end
            1:
            begin
                mode_value = 8'h01;
                addr_value = 8'hFF;
                func_value = 8'hFF;
            end
            // Only the low bit of the mode value counts.
            2: mode_value = 8'hFE;
            default: ;
        endcase
        cfg_write(mrfm_pkg::REG_RESPONSE_MODE, mode_value);
        cfg_write(mrfm_pkg::REG_DEVICE_ADDRESS, addr_value);
        cfg_write(mrfm_pkg::REG_FUNCTION_CODE, func_value);
        if (phase == 2 || $urandom_range(0, 2) == 0)
        begin
            cfg_write(REG_UNUSED, 8'($urandom_range(0, 255)));
        end
    endtask

    // Main sequence: reset, directed frames, random phases, quiet tail, verdict.
    initial
    begin
        int phase;
        int random_start;
        phase = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings, full frame with the signed extremes.
        emit_frame(FRAME_GOOD, '{8'h80, 8'h00, 8'h00, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF,
                                 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        settle();
        // Position-only frame with an all-zero value.
        cfg_write(mrfm_pkg::REG_RESPONSE_MODE, 8'h00);
        emit_frame(FRAME_GOOD, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                 8'h00, 8'h00, 8'h00, 8'h00});
        settle();

        // Random phases; the window is kept across each mode change.
        random_start = byte_count;
        while (byte_count - random_start < 600)
        begin
            configure_phase(phase);
            run_traffic(90 + $urandom_range(0, 20));
            settle();
            phase++;
        end

        // Last stretch without any idling.
        quiet = 1'b1;
        configure_phase(phase);
        run_traffic(60);
        settle();

        if (sb.pending_readings.size() != 0)
        begin
            $display("%0d predicted readings never arrived", sb.pending_readings.size());
            sb.fail_count++;
        end
        if (sb.fail_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
